### rtl/core/aia_pkg.sv
`default_nettype none

package aia_pkg;

    localparam int AIA_CAPACITY = 256;
    localparam int VALUE_W      = 32;
    localparam int POS_W        = 9;
    localparam int FOUND_W      = 8;
    localparam int COUNT_W      = 9;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_READ   = 2'd2,
        REQ_FIND   = 2'd3
    } t_req_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef struct packed {
        t_req_kind                 req_type;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] value;
    } t_req;

    typedef struct packed {
        t_status                   status;
        logic signed [VALUE_W-1:0] read_value;
        logic [FOUND_W-1:0]        found_position;
        logic [COUNT_W-1:0]        element_count;
    } t_rsp;

endpackage

`default_nettype wire

### rtl/core/aia_ram.sv
`default_nettype none

module aia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/aia_seq.sv
`default_nettype none

module aia_seq
    import aia_pkg::*;
#(
    parameter int CAPACITY = AIA_CAPACITY
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire t_req                        i_in_word,
    output logic                             o_done,
    output t_rsp                             o_rsp,
    input  wire logic                        i_out_free,
    output logic                             o_mem_we,
    output logic [$clog2(CAPACITY)-1:0]      o_mem_waddr,
    output logic [VALUE_W-1:0]               o_mem_wdata,
    output logic                             o_mem_re,
    output logic [$clog2(CAPACITY)-1:0]      o_mem_raddr,
    input  wire logic [VALUE_W-1:0]          i_mem_rdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INS_LAST,
        S_REM,
        S_READ,
        S_FIND,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [CW-1:0]      r_count;
    t_req               r_req;
    logic [AW-1:0]      r_rd_ptr;
    logic [AW-1:0]      r_rd_addr_q;
    logic               r_rd_more;
    logic               r_rd_valid;
    t_status            r_status;
    logic [VALUE_W-1:0] r_rv;
    logic [FOUND_W-1:0] r_found;

    logic               accept;
    logic [XW-1:0]      pos_x;
    logic [XW-1:0]      cnt_x;
    logic [AW-1:0]      last_idx;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign pos_x      = XW'(i_in_word.position);
    assign cnt_x      = XW'(r_count);
    assign last_idx   = AW'(r_count - CW'(1));

    assign o_done                = (r_state == S_DONE);
    assign o_rsp.status          = r_status;
    assign o_rsp.read_value      = r_rv;
    assign o_rsp.found_position  = r_found;
    assign o_rsp.element_count   = COUNT_W'(r_count);

    // read of entry a comes back on the next cycle and is written to a+1 or a-1
    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_waddr = r_rd_addr_q + AW'(1);
        o_mem_wdata = i_mem_rdata;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_rd_ptr;
        case (r_state)
            S_INS: begin
                o_mem_re = r_rd_more;
                o_mem_we = r_rd_valid;
            end
            S_INS_LAST: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = AW'(r_req.position);
                o_mem_wdata = r_req.value;
            end
            S_REM: begin
                o_mem_re    = r_rd_more;
                o_mem_we    = r_rd_valid;
                o_mem_waddr = r_rd_addr_q - AW'(1);
            end
            S_READ, S_FIND: begin
                o_mem_re = r_rd_more;
            end
            default: begin
                o_mem_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_rd_more  <= 1'b0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= o_mem_re;
            if (o_mem_re) begin
                r_rd_addr_q <= r_rd_ptr;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_req     <= i_in_word;
                        r_status  <= ST_OK;
                        r_rv      <= '0;
                        r_found   <= '0;
                        r_rd_more <= 1'b1;
                        case (i_in_word.req_type)
                            REQ_INSERT: begin
                                if (pos_x > cnt_x) begin
                                    r_status <= ST_RANGE;
                                    r_state  <= S_DONE;
                                end else if (r_count == CW'(CAPACITY)) begin
                                    r_status <= ST_FULL;
                                    r_state  <= S_DONE;
                                end else if (pos_x == cnt_x) begin
                                    r_state <= S_INS_LAST;
                                end else begin
                                    r_rd_ptr <= last_idx;
                                    r_state  <= S_INS;
                                end
                            end
                            REQ_REMOVE: begin
                                if (pos_x >= cnt_x) begin
                                    r_status <= ST_RANGE;
                                    r_state  <= S_DONE;
                                end else if (pos_x == cnt_x - XW'(1)) begin
                                    r_count <= r_count - CW'(1);
                                    r_state <= S_DONE;
                                end else begin
                                    r_rd_ptr <= AW'(pos_x + XW'(1));
                                    r_state  <= S_REM;
                                end
                            end
                            REQ_READ: begin
                                if (pos_x >= cnt_x) begin
                                    r_status <= ST_RANGE;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_rd_ptr <= AW'(pos_x);
                                    r_state  <= S_READ;
                                end
                            end
                            default: begin
                                if (r_count == '0) begin
                                    r_status <= ST_NOTFOUND;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_rd_ptr <= '0;
                                    r_state  <= S_FIND;
                                end
                            end
                        endcase
                    end
                end
                S_INS: begin
                    if (o_mem_re) begin
                        if (r_rd_ptr == AW'(r_req.position)) begin
                            r_rd_more <= 1'b0;
                        end else begin
                            r_rd_ptr <= r_rd_ptr - AW'(1);
                        end
                    end
                    if (r_rd_valid && !r_rd_more) begin
                        r_state <= S_INS_LAST;
                    end
                end
                S_INS_LAST: begin
                    r_count <= r_count + CW'(1);
                    r_state <= S_DONE;
                end
                S_REM: begin
                    if (o_mem_re) begin
                        if (r_rd_ptr == last_idx) begin
                            r_rd_more <= 1'b0;
                        end else begin
                            r_rd_ptr <= r_rd_ptr + AW'(1);
                        end
                    end
                    if (r_rd_valid && !r_rd_more) begin
                        r_count <= r_count - CW'(1);
                        r_state <= S_DONE;
                    end
                end
                S_READ: begin
                    if (o_mem_re) begin
                        r_rd_more <= 1'b0;
                    end
                    if (r_rd_valid) begin
                        r_rv    <= i_mem_rdata;
                        r_state <= S_DONE;
                    end
                end
                S_FIND: begin
                    if (o_mem_re) begin
                        if (r_rd_ptr == last_idx) begin
                            r_rd_more <= 1'b0;
                        end else begin
                            r_rd_ptr <= r_rd_ptr + AW'(1);
                        end
                    end
                    if (r_rd_valid) begin
                        if (i_mem_rdata == r_req.value) begin
                            // first hit wins, any read still in flight is dropped
                            r_found   <= FOUND_W'(r_rd_addr_q);
                            r_rd_more <= 1'b0;
                            r_state   <= S_DONE;
                        end else if (!r_rd_more) begin
                            r_status <= ST_NOTFOUND;
                            r_state  <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    r_rd_more <= 1'b0;
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem_we && o_mem_re) |-> (o_mem_waddr != o_mem_raddr))
        else $error("shift reads and writes the same entry");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count))) |->
            ((r_count == $past(r_count) + CW'(1)) || (r_count == $past(r_count) - CW'(1))))
        else $error("element count moved by more than one");

endmodule

`default_nettype wire

### rtl/core/indexed_array_insert_remove_search.sv
// rejected requests and removal of the last entry finish without a memory access; a read
// fetches one entry; insert shifts the entries from position to the end up by one, other
// removes shift the ones past position down by one, find scans from 0 up to the first hit; the
// memory walk moves one entry per cycle; one request at a time, so the next word is taken
// once the result sits in the output register, even while it waits there
// reset (synchronous, active low) empties the array; memory contents are not cleared
`default_nettype none

module indexed_array_insert_remove_search
    import aia_pkg::*;
#(
    parameter int CAPACITY = AIA_CAPACITY
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_req i_in_word,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_rsp      o_out_word
);

    localparam int AW = $clog2(CAPACITY);

    logic               seq_done;
    t_rsp               seq_rsp;
    logic               out_free;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic [VALUE_W-1:0] mem_rdata;

    logic               r_out_valid;
    t_rsp               r_out_word;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    aia_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_done      (seq_done),
        .o_rsp       (seq_rsp),
        .i_out_free  (out_free),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    aia_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // output word register, loaded when empty or being taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_done && out_free) begin
            r_out_valid <= 1'b1;
            r_out_word  <= seq_rsp;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.status != ST_OK)) |->
            ((o_out_word.read_value == '0) && (o_out_word.found_position == '0)))
        else $error("failed request carries data");

    a_only_one_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_out_word.read_value == '0) || (o_out_word.found_position == '0)))
        else $error("read value and found position both set");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("stalled result word changed");

endmodule

`default_nettype wire

### tb/tb_indexed_array_insert_remove_search.sv
`timescale 1ns / 1ps

module tb_indexed_array_insert_remove_search;
    import aia_pkg::*;

    localparam int CAP         = AIA_CAPACITY;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_req i_in_word;
    logic o_out_valid;
    logic i_out_stall;
    t_rsp o_out_word;

    indexed_array_insert_remove_search i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    // shadow of the array contents and fill count
    logic signed [VALUE_W-1:0] arr_model [0:CAP-1];
    int   arr_count;
    t_rsp pending_results[$];
    t_rsp want_rsp;
    int   mismatch_count;
    bit   tx_idle_en;
    bit   rx_idle_en;
    int   rx_hold_left;
    int   rx_burst_left;
    int   quiet_cycles;

    wire word_in_taken  = i_rst_n && i_in_valid && !o_in_stall;
    wire word_out_taken = i_rst_n && o_out_valid && !i_out_stall;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_rsp apply_request(input t_req r);
        t_rsp rsp;
        int   pos;
        int   where;
        bit   hit;
        rsp = '0;
        rsp.status = ST_OK;
        pos = r.position;
        hit = 1'b0;
        where = 0;
        case (r.req_type)
            REQ_INSERT: begin
                if (pos > arr_count) begin
                    rsp.status = ST_RANGE;
                end else if (arr_count >= CAP) begin
                    rsp.status = ST_FULL;
                end else begin
                    for (int i = arr_count; i > pos; i--) arr_model[i] = arr_model[i-1];
                    arr_model[pos] = r.value;
                    arr_count++;
                end
            end
            REQ_REMOVE: begin
                if (pos >= arr_count) begin
                    rsp.status = ST_RANGE;
                end else begin
                    for (int i = pos; i + 1 < arr_count; i++) arr_model[i] = arr_model[i+1];
                    arr_count--;
                end
            end
            REQ_READ: begin
                if (pos >= arr_count) rsp.status = ST_RANGE;
                else rsp.read_value = arr_model[pos];
            end
            default: begin
                for (int i = 0; i < arr_count; i++) begin
                    if (!hit && arr_model[i] == r.value) begin
                        hit = 1'b1;
                        where = i;
                    end
                end
                if (hit) rsp.found_position = where[FOUND_W-1:0];
                else rsp.status = ST_NOTFOUND;
            end
        endcase
        rsp.element_count = arr_count[COUNT_W-1:0];
        return rsp;
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        case (roll)
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return -32'sd1;
            3:       return 32'sd0;
            4, 5:    return $urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    // count is steered toward band_hi: inserts favored below it, removes above
    function automatic t_req make_random_req(input int band_hi);
        t_req r;
        int   roll;
        int   p_ins;
        r = '0;
        r.value = pick_value();
        p_ins = (arr_count < 4) ? 60 : (arr_count >= band_hi) ? 15 : 45;
        roll = $urandom_range(0, 99);
        if (roll < p_ins) r.req_type = REQ_INSERT;
        else if (roll < 70) r.req_type = REQ_REMOVE;
        else if (roll < 85) r.req_type = REQ_READ;
        else r.req_type = REQ_FIND;
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            r.position = POS_W'($urandom_range(0, CAP));
        end else if (roll < 11) begin
            r.position = POS_W'(CAP);
        end else if (roll < 14) begin
            r.position = POS_W'(arr_count);
        end else if (r.req_type == REQ_INSERT) begin
            r.position = POS_W'($urandom_range(0, arr_count));
        end else if (arr_count > 0) begin
            r.position = POS_W'($urandom_range(0, arr_count - 1));
        end
        if (r.req_type == REQ_FIND && arr_count > 0 && $urandom_range(0, 2) != 0)
            r.value = arr_model[$urandom_range(0, arr_count - 1)];
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // valid stays high after a word goes in, so back-to-back words need no gap
    task automatic send_req(input t_req w);
        int gap;
        if (tx_idle_en && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 9);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(apply_request(w));
    endtask

    task automatic send_op(input t_req_kind kind, input int pos,
                           input logic signed [VALUE_W-1:0] val);
        t_req r;
        r.req_type = kind;
        r.position = POS_W'(pos);
        r.value    = val;
        send_req(r);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_empty_array();
        send_op(REQ_READ, 0, 32'sd5);
        send_op(REQ_REMOVE, 0, 32'sd0);
        send_op(REQ_FIND, 0, 32'sd0);
        send_op(REQ_INSERT, 1, 32'sd9);
        send_op(REQ_INSERT, CAP, -32'sd1);
        send_op(REQ_READ, CAP, 32'sd0);
    endtask

    task automatic test_edit_ops();
        send_op(REQ_INSERT, 0, 32'sh7fff_ffff);
        send_op(REQ_INSERT, 0, 32'sh8000_0000);
        send_op(REQ_INSERT, 2, -32'sd1);
        send_op(REQ_INSERT, 1, 32'sd0);
        send_op(REQ_INSERT, 5, 32'sd3);
        send_op(REQ_INSERT, 2, -32'sd1);
        send_op(REQ_READ, 0, 32'sd0);
        send_op(REQ_READ, 4, 32'sd0);
        send_op(REQ_READ, 5, 32'sd0);
        // duplicate value, first index must win
        send_op(REQ_FIND, 0, -32'sd1);
        send_op(REQ_FIND, 0, 32'sh8000_0000);
        send_op(REQ_FIND, 0, 32'sd12345);
        send_op(REQ_REMOVE, 1, 32'sd0);
        send_op(REQ_REMOVE, 3, 32'sd0);
        send_op(REQ_REMOVE, 0, 32'sd0);
        send_op(REQ_REMOVE, 2, 32'sd0);
        send_op(REQ_READ, 1, 32'sd0);
        send_op(REQ_FIND, 0, 32'sh7fff_ffff);
        send_op(REQ_READ, CAP, 32'sd0);
    endtask

    task automatic test_fill_to_capacity();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        while (arr_count < CAP) send_op(REQ_INSERT, arr_count, pick_value());
        send_op(REQ_INSERT, CAP, 32'sd1);
        send_op(REQ_INSERT, 0, 32'sd1);
        send_op(REQ_INSERT, 100, 32'sd1);
        send_op(REQ_READ, CAP - 1, 32'sd0);
        send_op(REQ_READ, CAP, 32'sd0);
        send_op(REQ_FIND, 0, arr_model[CAP-1]);
        send_op(REQ_FIND, 0, $urandom);
        send_op(REQ_REMOVE, CAP - 1, 32'sd0);
        send_op(REQ_REMOVE, 0, 32'sd0);
        send_op(REQ_INSERT, CAP - 1, 32'sd77);
        while (arr_count > 16) send_op(REQ_REMOVE, $urandom_range(0, arr_count - 1), 32'sd0);
        wait_drained();
    endtask

    // receiver holds off long enough that the block backs up and stalls its input
    task automatic test_output_hold();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        rx_hold_left = HOLD_CYCLES;
        repeat (10) send_req(make_random_req(32));
        wait_drained();
    endtask

    task automatic test_random_traffic(input int n_items, input int band_hi);
        for (int k = 0; k < n_items; k++) begin
            if (k % 64 == 0) begin
                tx_idle_en = ($urandom_range(0, 3) != 0);
                rx_idle_en = ($urandom_range(0, 3) != 0);
            end
            send_req(make_random_req(band_hi));
        end
    endtask

    task automatic test_steady_stream(input int n_items);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (n_items) send_req(make_random_req(24));
    endtask

    // output side stall: long hold when asked, otherwise random bursts
    initial begin
        i_out_stall   = 1'b0;
        rx_hold_left  = 0;
        rx_burst_left = 0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_left > 0) begin
                i_out_stall <= 1'b1;
                rx_hold_left--;
            end else if (rx_burst_left > 0) begin
                i_out_stall <= 1'b1;
                rx_burst_left--;
            end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
                i_out_stall <= 1'b1;
                rx_burst_left = $urandom_range(1, 9) - 1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (word_out_taken) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("result word with nothing pending");
            end else begin
                want_rsp = pending_results.pop_front();
                if (o_out_word.status !== want_rsp.status)
                    flag_mismatch($sformatf("status got %0d want %0d",
                                            o_out_word.status, want_rsp.status));
                if (o_out_word.read_value !== want_rsp.read_value)
                    flag_mismatch($sformatf("read_value got %0d want %0d",
                                            o_out_word.read_value, want_rsp.read_value));
                if (o_out_word.found_position !== want_rsp.found_position)
                    flag_mismatch($sformatf("found_position got %0d want %0d",
                                            o_out_word.found_position,
                                            want_rsp.found_position));
                if (o_out_word.element_count !== want_rsp.element_count)
                    flag_mismatch($sformatf("element_count got %0d want %0d",
                                            o_out_word.element_count,
                                            want_rsp.element_count));
            end
        end
    end

    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (word_in_taken || word_out_taken) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_word      = '0;
        tx_idle_en     = 1'b0;
        rx_idle_en     = 1'b0;
        arr_count      = 0;
        mismatch_count = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_array();
        test_edit_ops();
        test_fill_to_capacity();
        test_output_hold();
        test_random_traffic(550, 32);
        test_random_traffic(250, 160);
        test_random_traffic(150, 12);
        test_steady_stream(100);

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
